// ===== rtl/ghist_pkg.sv =====
`default_nettype none
package ghist_pkg;

  // Store geometry
  localparam int LEVELS     = 256;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Fixed field widths
  localparam int GRAY_W     = 8;
  localparam int OUT_CNT_W  = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};
  localparam logic [OUT_CNT_W-1:0]  OUT_COUNT_MAX = {OUT_CNT_W{1'b1}};
  localparam logic [GRAY_W-1:0]     MAX_GRAY_RST  = {GRAY_W{1'b1}};

  typedef enum logic {
    FUNC_ACCUM = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  // Write request from the update stage to the count store
  typedef struct packed {
    logic                  en;
    logic                  clr;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
  } ghist_wr_t;

endpackage
`default_nettype wire

// ===== rtl/ghist_if.sv =====
`default_nettype none
interface ghist_in_if;
  import ghist_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [GRAY_W-1:0] pixel_value;
  logic [GRAY_W-1:0] read_bin;

  modport source (output valid, func, pixel_value, read_bin, input ready);
  modport sink   (input valid, func, pixel_value, read_bin, output ready);
endinterface

interface ghist_out_if;
  import ghist_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [GRAY_W-1:0]    bin_index;
  logic [OUT_CNT_W-1:0] bin_count;

  modport source (output valid, bin_index, bin_count, input ready);
  modport sink   (input valid, bin_index, bin_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/ghist_store.sv =====
`default_nettype none
module ghist_store import ghist_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  output logic      [COUNT_BITS-1:0] rd_data,
  input  wire ghist_wr_t             wr
);

  logic [COUNT_BITS-1:0] mem [LEVELS];
  logic [LEVELS-1:0]     filled;

  // Count array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en && !wr.clr) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= filled[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // Per-bin valid flags; an unwritten or cleared bin reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr.en) begin
      filled[wr.addr] <= !wr.clr;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gray_level_histogram_unit.sv =====
`default_nettype none
// Gray-level histogram unit. Items on "items" either count one pixel
// (func 0) or read and clear one bin (func 1); only reads give a result on
// "results", registered through the update stage and the result register,
// echoing the bin and its count saturated to 16 bits. Pixels and reads
// above max_gray address no bin: pixels are dropped, reads return zero.
// Counts are held in a one-port-read, one-port-write RAM with a registered
// read; a bin is read on transfer, updated the next cycle and written back,
// with a one-entry bypass for back-to-back hits on the same bin. Accumulate
// items are taken one per cycle; in the cycle after a read transfer the
// input pauses, and it also waits while a result is held by the downstream
// side. The store is empty right after reset with no clearing pass. Write
// max_gray only while no item is in flight.
module gray_level_histogram_unit import ghist_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [GRAY_W-1:0] cfg_wdata,
  ghist_in_if.sink               items,
  ghist_out_if.source            results
);

  logic [GRAY_W-1:0]     max_gray;
  logic                  accept;
  logic [ADDR_W-1:0]     rd_addr;
  logic [COUNT_BITS-1:0] rd_data;

  logic                  s1_valid;
  logic                  s1_func;
  logic [GRAY_W-1:0]     s1_pix;
  logic [GRAY_W-1:0]     s1_bin;
  logic [GRAY_W-1:0]     s1_key;
  logic                  s1_in_use;
  logic [COUNT_BITS-1:0] s1_cur;

  logic                  fwd_valid;
  logic [ADDR_W-1:0]     fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;

  logic                  out_valid;
  logic [GRAY_W-1:0]     out_index;
  logic [OUT_CNT_W-1:0]  out_count;
  logic [OUT_CNT_W-1:0]  sat_count;

  ghist_wr_t             wr;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gray <= MAX_GRAY_RST;
    end else if (cfg_we) begin
      max_gray <= cfg_wdata;
    end
  end

  // Input side: hold off after a read and while a result is stalled, so the result register has room
  assign items.ready = !(s1_valid && s1_func == FUNC_READ) && (!out_valid || results.ready);
  assign accept      = items.valid && items.ready;
  assign rd_addr     = (items.func == FUNC_READ) ? ADDR_W'(items.read_bin)
                                                 : ADDR_W'(items.pixel_value);

  ghist_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // Update stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= items.func;
      s1_pix  <= items.pixel_value;
      s1_bin  <= items.read_bin;
    end
  end

  // Bin selection and current count with bypass of the last write
  assign s1_key    = (s1_func == FUNC_READ) ? s1_bin : s1_pix;
  assign s1_in_use = (s1_key <= max_gray) && (32'(s1_key) < LEVELS);
  assign s1_cur    = (fwd_valid && fwd_addr == ADDR_W'(s1_key)) ? fwd_data : rd_data;

  // Write back: increment with saturation, or clear on read
  always_comb begin
    wr.en   = s1_valid && s1_in_use;
    wr.clr  = (s1_func == FUNC_READ);
    wr.addr = ADDR_W'(s1_key);
    if (s1_func == FUNC_READ) begin
      wr.data = '0;
    end else if (s1_cur == COUNT_MAX) begin
      wr.data = s1_cur;
    end else begin
      wr.data = s1_cur + COUNT_BITS'(1);
    end
  end

  // One-entry bypass covering the read that overlapped this write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr.en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_addr <= wr.addr;
      fwd_data <= wr.data;
    end
  end

  // Output count, saturated to the field width
  assign sat_count = (32'(s1_cur) > 32'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                       : OUT_CNT_W'(s1_cur);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_func == FUNC_READ) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_func == FUNC_READ) begin
      out_index <= s1_bin;
      out_count <= s1_in_use ? sat_count : '0;
    end
  end

  assign results.valid     = out_valid;
  assign results.bin_index = out_index;
  assign results.bin_count = out_count;

endmodule
`default_nettype wire

// ===== rtl/ghist_checker.sv =====
`default_nettype none
module ghist_checker import ghist_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 in_func,
  input wire logic [GRAY_W-1:0]    in_read_bin,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [GRAY_W-1:0]    out_bin_index,
  input wire logic [OUT_CNT_W-1:0] out_bin_count
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // Nothing left on the output after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_bin_index)
                                   && $stable(out_bin_count)))
    else $error("stalled result changed");

  // A read transfer drops the input ready in the cycle after it
  a_read_pause: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_func == FUNC_READ) |=> !in_ready)
    else $error("input taken right after a read");

  // A read gives its result after the update stage, echoing the bin
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_func == FUNC_READ) |-> ##2
      (out_valid && out_bin_index == $past(in_read_bin, 2)))
    else $error("read result missing or wrong bin");

  // An accumulate never produces a result
  a_accum_silent: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_func == FUNC_ACCUM && !out_valid) |=> !out_valid)
    else $error("result appeared for an accumulate");

endmodule

bind gray_level_histogram_unit ghist_checker u_ghist_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .in_func       (items.func),
  .in_read_bin   (items.read_bin),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_bin_index (results.bin_index),
  .out_bin_count (results.bin_count)
);
`default_nettype wire
